FILE: hdl/serial_lcd_page_writer_core_macros.svh
// assertion helpers for the serial lcd page writer
`ifndef SERIAL_LCD_PAGE_WRITER_CORE_MACROS_SVH
`define SERIAL_LCD_PAGE_WRITER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// antecedent in the current cycle implies consequent in the same cycle
`define SLPW_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("slpw: implication check failed");

// condition holds at every edge out of reset
`define SLPW_ASSERT_ALWAYS(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) \
    else $error("slpw: invariant check failed");

`else

`define SLPW_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define SLPW_ASSERT_ALWAYS(lbl, clk_s, rstn_s, cond)

`endif

`endif

FILE: hdl/slpw_pkg.sv
`default_nettype none
package slpw_pkg;

  // display geometry defaults
  localparam int DEF_DISPLAY_WIDTH  = 128;
  localparam int DEF_DISPLAY_HEIGHT = 64;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // frame constants
  localparam logic [7:0] SYNC_CMD  = 8'hF8;
  localparam logic [7:0] SYNC_DATA = 8'hFA;
  localparam logic [7:0] NIB_MASK  = 8'hF0;
  localparam logic [7:0] ADDR_BASE = 8'h80;
  localparam logic [7:0] COL_FOLD  = 8'h08;
  localparam int         FOLD_ROW  = 32;

  // rows-per-page register
  localparam int         RPP_W     = 7;
  localparam logic [6:0] RPP_RESET = 7'd16;
  localparam int         RPP_MAX   = 64;

  // out tuser bit positions
  localparam int TU_PAUSE   = 0;
  localparam int TU_SELECT  = 1;
  localparam int TU_RELEASE = 2;
  localparam int TU_W       = 3;

  // one classified item handed from front to back
  typedef struct packed {
    logic       row_start;
    logic       fold;
    logic [4:0] row_y;
    logic [7:0] data;
    logic       select;
    logic       rel;
    logic       row_end;
  } slpw_cmd_t;

endpackage
`default_nettype wire

FILE: hdl/slpw_front.sv
`default_nettype none
`include "serial_lcd_page_writer_core_macros.svh"
module slpw_front #(
  parameter int DISPLAY_WIDTH  = slpw_pkg::DEF_DISPLAY_WIDTH,
  parameter int DISPLAY_HEIGHT = slpw_pkg::DEF_DISPLAY_HEIGHT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  input  wire logic [6:0]           cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 first_of_page,
  input  wire logic [5:0]           page_start_row,
  input  wire logic                 q_full,
  output logic                      q_push,
  output slpw_pkg::slpw_cmd_t       q_cmd
);
  import slpw_pkg::*;

  localparam int BPR    = DISPLAY_WIDTH / 8;
  localparam int BCOL_W = (BPR > 1) ? $clog2(BPR) : 1;

  logic [5:0]        row_r, row_nxt;
  logic [BCOL_W-1:0] col_r, col_nxt;
  logic [6:0]        sent_r, sent_nxt;
  logic              in_page_r, in_page_nxt;
  logic [6:0]        rpp_r, rpp_nxt;

  logic [5:0]        start_row, row_cur, row_inc;
  logic [BCOL_W-1:0] col_cur;
  logic [6:0]        sent_cur, sent_inc, limit;
  logic              active, row_end, done, take;

  // clamp rows per page to 1..64
  always_comb begin
    if (rpp_r == '0) begin
      limit = 7'd1;
    end else if (rpp_r > 7'(RPP_MAX)) begin
      limit = 7'(RPP_MAX);
    end else begin
      limit = rpp_r;
    end
  end

  // page start row wrapped into the display height, a constant lookup
  always_comb begin
    start_row = '0;
    for (int i = 0; i < 64; i++) begin
      if (page_start_row == 6'(i)) begin
        start_row = 6'(i % DISPLAY_HEIGHT);
      end
    end
  end

  // classify the incoming item against the page position
  always_comb begin
    row_cur   = first_of_page ? start_row : row_r;
    col_cur   = first_of_page ? '0 : col_r;
    sent_cur  = first_of_page ? '0 : sent_r;
    active    = first_of_page || in_page_r;
    row_end   = (col_cur == BCOL_W'(BPR - 1));
    sent_inc  = sent_cur + 7'd1;
    done      = row_end && (sent_inc >= limit);
    row_inc   = (row_cur == 6'(DISPLAY_HEIGHT - 1)) ? 6'd0 : row_cur + 6'd1;
    take      = in_valid && in_ready;

    q_push          = take && active;
    q_cmd.row_start = (col_cur == '0);
    q_cmd.fold      = (row_cur >= 6'(FOLD_ROW));
    q_cmd.row_y     = row_cur[4:0];
    q_cmd.data      = data_byte;
    q_cmd.select    = first_of_page;
    q_cmd.rel       = done;
    q_cmd.row_end   = row_end;
  end

  assign in_ready = !q_full;

  // next page position
  always_comb begin
    row_nxt     = row_r;
    col_nxt     = col_r;
    sent_nxt    = sent_r;
    in_page_nxt = in_page_r;
    rpp_nxt     = cfg_valid ? cfg_data : rpp_r;
    if (take && active) begin
      if (row_end) begin
        col_nxt     = '0;
        row_nxt     = row_inc;
        sent_nxt    = done ? 7'd0 : sent_inc;
        in_page_nxt = !done;
      end else begin
        col_nxt     = col_cur + BCOL_W'(1);
        row_nxt     = row_cur;
        sent_nxt    = sent_cur;
        in_page_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      col_r     <= '0;
      sent_r    <= '0;
      in_page_r <= 1'b0;
      rpp_r     <= RPP_RESET;
    end else begin
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      sent_r    <= sent_nxt;
      in_page_r <= in_page_nxt;
      rpp_r     <= rpp_nxt;
    end
  end

  // rows already sent always stay below RPP_MAX
  `SLPW_ASSERT_ALWAYS(a_sent_below_limit, clk, rst_n, sent_r < 7'(RPP_MAX))

endmodule
`default_nettype wire

FILE: hdl/slpw_queue.sv
`default_nettype none
`include "serial_lcd_page_writer_core_macros.svh"
module slpw_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output logic [WIDTH-1:0]      head_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  // occupancy and pointers
  always_comb begin
    full       = (count_r == CW'(DEPTH));
    head_valid = (count_r != '0);
    head_data  = mem_r[rd_ptr_r];
    do_push    = push && !full;
    do_pop     = pop && head_valid;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `SLPW_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CW'(DEPTH))
  `SLPW_ASSERT_IMP(a_no_push_full, clk, rst_n, full, !push)

endmodule
`default_nettype wire

FILE: hdl/slpw_back.sv
`default_nettype none
`include "serial_lcd_page_writer_core_macros.svh"
module slpw_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      q_valid,
  input  wire slpw_pkg::slpw_cmd_t       q_cmd,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [7:0]                     out_tdata,
  output logic [slpw_pkg::TU_W-1:0]      out_tuser,
  output logic                           out_tlast
);
  import slpw_pkg::*;

  typedef enum logic [2:0] {
    PH_SYNC_CMD,
    PH_ROW_HI,
    PH_ROW_LO,
    PH_COL_HI,
    PH_COL_LO,
    PH_SYNC_DATA,
    PH_DATA_HI,
    PH_DATA_LO
  } phase_t;

  phase_t          phase_r, phase_nxt, phase_eff;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_data_r, out_data_nxt;
  logic [TU_W-1:0] out_user_r, out_user_nxt;
  logic            out_last_r, out_last_nxt;
  logic            load, emit;
  logic [7:0]      frame;
  logic            pause;

  // items without a row header start at the data frames
  always_comb begin
    if (phase_r == PH_SYNC_CMD && !q_cmd.row_start) begin
      phase_eff = PH_DATA_HI;
    end else begin
      phase_eff = phase_r;
    end
  end

  // frame and pause flag for the current phase
  always_comb begin
    case (phase_eff)
      PH_SYNC_CMD: begin
        frame = SYNC_CMD;
        pause = 1'b1;
      end
      PH_ROW_HI: begin
        frame = ADDR_BASE | {3'b000, q_cmd.row_y[4], 4'b0000};
        pause = 1'b0;
      end
      PH_ROW_LO: begin
        frame = {q_cmd.row_y[3:0], 4'b0000};
        pause = 1'b1;
      end
      PH_COL_HI: begin
        frame = ADDR_BASE & NIB_MASK;
        pause = 1'b0;
      end
      PH_COL_LO: begin
        frame = q_cmd.fold ? {COL_FOLD[3:0], 4'b0000} : 8'h00;
        pause = 1'b1;
      end
      PH_SYNC_DATA: begin
        frame = SYNC_DATA;
        pause = 1'b1;
      end
      PH_DATA_HI: begin
        frame = q_cmd.data & NIB_MASK;
        pause = 1'b0;
      end
      PH_DATA_LO: begin
        frame = {q_cmd.data[3:0], 4'b0000};
        pause = q_cmd.row_end;
      end
      default: begin
        frame = '0;
        pause = 1'b0;
      end
    endcase
  end

  // output register advances when empty or taken
  always_comb begin
    load          = !out_valid_r || out_tready;
    emit          = load && q_valid;
    q_pop         = emit && (phase_eff == PH_DATA_LO);
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    if (load) begin
      out_valid_nxt = q_valid;
    end
    if (emit) begin
      phase_nxt                = q_pop ? PH_SYNC_CMD : phase_t'(phase_eff + 3'd1);
      out_data_nxt             = frame;
      out_user_nxt[TU_PAUSE]   = pause;
      out_user_nxt[TU_SELECT]  = q_cmd.select && (phase_r == PH_SYNC_CMD);
      out_user_nxt[TU_RELEASE] = q_cmd.rel && (phase_eff == PH_DATA_LO);
      out_last_nxt             = (phase_eff == PH_DATA_LO);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SYNC_CMD;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // chip select is released only on the closing frame of an item
  `SLPW_ASSERT_IMP(a_rel_on_last, clk, rst_n, out_valid_r && out_user_r[TU_RELEASE], out_last_r)
  // a page always opens with the command sync frame
  `SLPW_ASSERT_IMP(a_sel_on_sync, clk, rst_n, out_valid_r && out_user_r[TU_SELECT],
                   out_data_r == SYNC_CMD)

endmodule
`default_nettype wire

FILE: hdl/serial_lcd_page_writer_core.sv
`default_nettype none
// Turns page-buffer bytes for a serial graphics LCD into 8-bit controller frames.
// An item that opens a display row produces eight frames (command sync, row address
// high/low, column address high/low, data sync, data high/low); any other byte
// produces two. The output channel carries one frame per cycle while out_tready is
// high, each frame set by the frame sequencer in the back end; the front end keeps
// accepting bytes into a two-entry queue meanwhile. Bytes arriving with no page open
// are consumed and produce nothing. in_tdata: [7:0] data_byte, [13:8] page_start_row,
// [15:14] zero; in_tuser: first_of_page. out_tdata: frame_byte; out_tuser:
// [0] pause_after, [1] select_before, [2] release_after; out_tlast: last_frame.
// cfg_data sets rows per page and should be written only while the block is idle.
module serial_lcd_page_writer_core #(
  parameter int DISPLAY_WIDTH  = slpw_pkg::DEF_DISPLAY_WIDTH,
  parameter int DISPLAY_HEIGHT = slpw_pkg::DEF_DISPLAY_HEIGHT
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // config: rows_per_page
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [6:0]                cfg_data,
  // in_tdata: data_byte [7:0], page_start_row [13:8], pad [15:14]
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [15:0]               in_tdata,
  // in_tuser: first_of_page
  input  wire logic [0:0]                in_tuser,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // out_tdata: frame_byte [7:0]
  output logic [7:0]                     out_tdata,
  // out_tuser: pause_after [0], select_before [1], release_after [2]
  output logic [slpw_pkg::TU_W-1:0]      out_tuser,
  output logic                           out_tlast
);
  import slpw_pkg::*;

  localparam int CMD_W = $bits(slpw_cmd_t);

  slpw_cmd_t        push_cmd, head_cmd;
  logic [CMD_W-1:0] head_bits;
  logic             q_push, q_full, q_pop, q_valid;

  assign cfg_ready = 1'b1;

  // front: page bookkeeping and item classification
  slpw_front #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .data_byte      (in_tdata[7:0]),
    .first_of_page  (in_tuser[0]),
    .page_start_row (in_tdata[13:8]),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (push_cmd)
  );

  // short queue between front and back
  slpw_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (head_bits)
  );

  assign head_cmd = slpw_cmd_t'(head_bits);

  // back: frame sequencer and output register
  slpw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

FILE: verif/tb_serial_lcd_page_writer_core.sv
`timescale 1ns / 1ps
module tb_serial_lcd_page_writer_core;
  import slpw_pkg::*;

  localparam int BYTES_PER_ROW = DEF_DISPLAY_WIDTH / 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 20;

  // one serial frame as it leaves the block
  typedef struct {
    logic [7:0] frame_byte;
    logic       pause_after;
    logic       select_before;
    logic       release_after;
    logic       last_frame;
  } lcd_frame_t;

  // row/column tracker and the queue of frames still owed by the block
  class lcd_frame_scoreboard;
    lcd_frame_t frames_due[$];
    lcd_frame_t burst[$];
    logic [5:0] cur_row;
    logic [3:0] byte_col;
    logic [6:0] rows_sent;
    bit         page_open;
    logic [6:0] rows_per_page;
    int         mismatches;
    int         frames_checked;
    int         rows_started;
    int         pages_released;

    function new();
      cur_row        = '0;
      byte_col       = '0;
      rows_sent      = '0;
      page_open      = 1'b0;
      rows_per_page  = RPP_RESET;
      mismatches     = 0;
      frames_checked = 0;
      rows_started   = 0;
      pages_released = 0;
    endfunction

    function void set_rows_per_page(logic [6:0] v);
      rows_per_page = v;
    endfunction

    // zero acts as one row, anything above the display acts as the full display
    function int effective_rows();
      if (rows_per_page == 0) return 1;
      if (rows_per_page > RPP_MAX) return RPP_MAX;
      return rows_per_page;
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    function void add_frame(logic [7:0] v, logic p);
      lcd_frame_t f;
      f.frame_byte    = v;
      f.pause_after   = p;
      f.select_before = 1'b0;
      f.release_after = 1'b0;
      f.last_frame    = 1'b0;
      burst.push_back(f);
    endfunction

    // high nibble frame, then low nibble moved up
    function void add_split(logic [7:0] v, logic p);
      add_frame(v & NIB_MASK, 1'b0);
      add_frame({v[3:0], 4'h0}, p);
    endfunction

    // work out the frames one accepted byte owes
    function void note_byte(logic [7:0] data, logic first, logic [5:0] start);
      logic [5:0] y;
      logic [7:0] col;
      bit         row_end;
      burst.delete();
      if (first) begin
        cur_row   = 6'(int'(start) % DEF_DISPLAY_HEIGHT);
        byte_col  = '0;
        rows_sent = '0;
        page_open = 1'b1;
      end else if (!page_open) begin
        return;
      end
      // row header: command sync, row and column address, data sync
      if (byte_col == 0) begin
        y   = cur_row;
        col = ADDR_BASE;
        if (y >= FOLD_ROW) begin
          y   = y - 6'(FOLD_ROW);
          col = ADDR_BASE | COL_FOLD;
        end
        add_frame(SYNC_CMD, 1'b1);
        add_split(ADDR_BASE | {2'b00, y}, 1'b1);
        add_split(col, 1'b1);
        add_frame(SYNC_DATA, 1'b1);
        rows_started++;
      end
      row_end = (int'(byte_col) + 1 >= BYTES_PER_ROW);
      add_split(data, row_end);
      if (first) burst[0].select_before = 1'b1;
      if (row_end) begin
        byte_col  = '0;
        rows_sent = rows_sent + 7'd1;
        cur_row   = 6'((int'(cur_row) + 1) % DEF_DISPLAY_HEIGHT);
        if (int'(rows_sent) >= effective_rows()) begin
          burst[burst.size() - 1].release_after = 1'b1;
          page_open = 1'b0;
          rows_sent = '0;
          pages_released++;
        end
      end else begin
        byte_col = byte_col + 4'd1;
      end
      burst[burst.size() - 1].last_frame = 1'b1;
      foreach (burst[i]) frames_due.push_back(burst[i]);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_frame(logic [7:0] fb, logic [TU_W-1:0] tu, logic lst);
      lcd_frame_t want;
      frames_checked++;
      if (frames_due.size() == 0) begin
        $error("frame %0h arrived with nothing pending", fb);
        mismatches++;
        return;
      end
      want = frames_due.pop_front();
      compare_field("frame_byte", want.frame_byte, fb);
      compare_field("pause_after", {7'd0, want.pause_after}, {7'd0, tu[TU_PAUSE]});
      compare_field("select_before", {7'd0, want.select_before}, {7'd0, tu[TU_SELECT]});
      compare_field("release_after", {7'd0, want.release_after}, {7'd0, tu[TU_RELEASE]});
      compare_field("last_frame", {7'd0, want.last_frame}, {7'd0, lst});
    endfunction
  endclass

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [6:0]        cfg_data   = '0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata   = '0;   // data_byte [7:0], page_start_row [13:8], pad
  logic [0:0]        in_tuser   = '0;   // first_of_page [0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;         // frame_byte [7:0]
  logic [TU_W-1:0]   out_tuser;         // pause_after [0], select_before [1], release_after [2]
  logic              out_tlast;

  lcd_frame_scoreboard sb;
  int tx_idle_pct = 25;
  int rx_idle_pct = 71;
  int items_sent  = 0;
  int cycles      = 0;

  serial_lcd_page_writer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // both handshakes watched in one place so notes and checks keep their order
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata[7:0], in_tuser[0], in_tdata[13:8]);
      if (out_tvalid && out_tready) sb.check_frame(out_tdata, out_tuser, out_tlast);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_serial_lcd_page_writer_core: FAIL");
      $finish;
    end
  end

  // present one item after an optional random gap, hold until taken
  task automatic send_item(input logic [7:0] d, input logic first, input logic [5:0] row);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, row, d};
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // stop input, let every owed frame out, then let the queue settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rows_per_page(input logic [6:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_rows_per_page(v);
  endtask

  // mostly whole pages with random content, some cut short, stray bytes between
  task automatic run_pages(input int n_items, input bit allow_cut);
    int         sent;
    int         full;
    int         len;
    logic [5:0] start;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 5))
        0: start = 6'd63;
        1: start = 6'd31;
        2: start = 6'd32;
        3: start = 6'd0;
        default: start = 6'($urandom_range(0, 63));
      endcase
      full = sb.effective_rows() * BYTES_PER_ROW;
      len  = (allow_cut && $urandom_range(0, 4) == 0) ? $urandom_range(1, full) : full;
      if (len > n_items - sent) len = n_items - sent;
      for (int i = 0; i < len; i++) begin
        send_item(8'($urandom_range(0, 255)), i == 0,
                  (i == 0) ? start : 6'($urandom_range(0, 63)));
      end
      sent += len;
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) send_item(8'($urandom), 1'b0, 6'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bytes with no page open are dropped
    send_item(8'h00, 1'b0, 6'd0);
    send_item(8'hFF, 1'b0, 6'd63);
    // page opens, then reopens mid-page at the last row, folded rows and the fold edge
    send_item(8'h00, 1'b1, 6'd0);
    send_item(8'hFF, 1'b0, 6'd0);
    send_item(8'h5A, 1'b1, 6'd63);
    send_item(8'hA5, 1'b0, 6'd0);
    send_item(8'h0F, 1'b1, 6'd32);
    send_item(8'hF0, 1'b1, 6'd31);

    // one-row page runs to release, then a stray byte
    write_rows_per_page(7'd1);
    for (int i = 0; i < BYTES_PER_ROW; i++) begin
      send_item(8'($urandom_range(0, 255)), i == 0, 6'd63);
    end
    send_item(8'h81, 1'b0, 6'd5);

    // zero rows acts as one
    write_rows_per_page(7'd0);
    run_pages(85, 1'b1);

    tx_idle_pct = 71;
    rx_idle_pct = 25;
    write_rows_per_page(7'd2);
    run_pages(85, 1'b1);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_rows_per_page(7'($urandom_range(1, 6)));
    run_pages(85, 1'b1);

    // above the display height acts as the full display, so two rows stay open
    write_rows_per_page(7'd127);
    for (int i = 0; i < 2 * BYTES_PER_ROW; i++) begin
      send_item(8'($urandom_range(0, 255)), i == 0, 6'd40);
    end
    send_item(8'h3C, 1'b0, 6'd17);

    drain();
    $display("sent %0d bytes, checked %0d frames", items_sent, sb.frames_checked);
    $display("opened %0d rows, closed %0d pages", sb.rows_started, sb.pages_released);
    if (sb.mismatches == 0) begin
      $display("tb_serial_lcd_page_writer_core: PASS");
    end else begin
      $display("tb_serial_lcd_page_writer_core: FAIL");
    end
    $finish;
  end

endmodule
